FILE: rtl/dts_pkg.sv
// shared types and constants for the topological sort block
package dts_pkg;
    localparam int NV = 64;
    localparam int VW = 6;
    localparam int CW = 7;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_SORT  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_WALK_POP,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_EMPTY
    } t_state;

    // lowest set bit index of a 64 bit word
    function automatic logic [VW-1:0] f_lowest(input logic [NV-1:0] m);
        logic [VW-1:0] r;
        r = VW'(NV - 1);
        for (int i = NV - 1; i >= 0; i--) begin
            if (m[i]) r = VW'(i);
        end
        return r;
    endfunction
endpackage

FILE: rtl/dts_if.sv
// valid/ready channel interfaces for the sort block
interface dts_in_if;
    import dts_pkg::*;
    logic          valid;
    logic          ready;
    logic [1:0]    action;
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    modport source (output valid, action, src, dst, input ready);
    modport sink (input valid, action, src, dst, output ready);
endinterface

interface dts_out_if;
    import dts_pkg::*;
    logic          valid;
    logic          ready;
    logic [VW-1:0] vertex;
    logic          last;
    logic          empty_res;
    modport source (output valid, vertex, last, empty_res, input ready);
    modport sink (input valid, vertex, last, empty_res, output ready);
endinterface

FILE: rtl/dfs_topological_sort.sv
// depth-first topological sort over a memory-held adjacency store
//
// i_in: transactions carrying action, src, dst. add loads one edge
// (read both rows, then write both rows back). clear sweeps both
// adjacency memories, one row per cycle. sort scans vertices in order;
// each start candidate reads one in row and an already visited vertex
// is skipped without a read. each step of the walk reads one out row
// from memory, and a pop back to a parent first takes the parent from
// the stack. order is then read back from the postorder memory, one
// vertex read and then sent at a time, on o_out in reverse postorder,
// last on the final vertex, or a single empty transaction.
// one item at a time: i_in.ready is high only when idle.
// reset: no edges, vertex_count 64. the adjacency memories are swept
// clear after reset before the first item is accepted.
// if o_out stalls, the result is held in the output register and the
// emission waits.
// i_cfg_we/i_cfg_data write vertex_count, clamped to 64; the user
// must write it only while idle, the block does not enforce it.
module dfs_topological_sort
    import dts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_data,
    dts_in_if.sink        i_in,
    dts_out_if.source     o_out
);
    // memories
    logic [NV-1:0] r_out_mem [NV];
    logic [NV-1:0] r_in_mem  [NV];
    logic [VW-1:0] r_stack   [NV];
    logic [VW-1:0] r_order   [NV];

    t_state r_state, n_state;
    logic [CW-1:0] r_vcnt;
    logic [CW-1:0] r_n;
    logic [NV-1:0] r_mask;
    logic [NV-1:0] r_visited, n_visited;
    logic [CW-1:0] r_depth, n_depth;
    logic [CW-1:0] r_ocnt, n_ocnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [VW-1:0] r_src, r_dst, r_top, n_top;
    logic [NV-1:0] r_rd_a, r_rd_b;
    logic [VW-1:0] r_stk_rd, r_ord_rd;
    logic          r_ov, n_ov;
    logic [VW-1:0] r_ovtx, n_ovtx;
    logic          r_olast, n_olast, r_oemp, n_oemp;

    // memory port controls
    logic          m_rd_en;
    logic [VW-1:0] m_rd_a, m_rd_b;
    logic          m_wr_en;
    logic [VW-1:0] m_wa_a, m_wa_b;
    logic [NV-1:0] m_out_a, m_in_a, m_out_b, m_in_b;
    logic          m_clr;
    logic          s_push, s_rec;
    logic [VW-1:0] s_push_v, s_ord_ra;

    logic [CW-1:0] w_cnt;
    logic [NV-1:0] w_next;
    logic          w_out_free;

    assign w_cnt = (i_cfg_data > CW'(NV)) ? CW'(NV) : i_cfg_data;
    assign w_out_free = !r_ov || o_out.ready;
    assign w_next = r_rd_a & r_mask & ~r_visited;

    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.vertex = r_ovtx;
    assign o_out.last = r_olast;
    assign o_out.empty_res = r_oemp;

    // adjacency memories: rows a and b read and written together
    always_ff @(posedge i_clk) begin
        if (m_rd_en) begin
            r_rd_a <= r_out_mem[m_rd_a];
            r_rd_b <= r_in_mem[m_rd_b];
        end
        if (m_clr) begin
            r_out_mem[r_idx[VW-1:0]] <= '0;
            r_in_mem[r_idx[VW-1:0]] <= '0;
        end else if (m_wr_en) begin
            r_out_mem[m_wa_a] <= m_out_a;
            r_in_mem[m_wa_a]  <= m_in_a;
            r_out_mem[m_wa_b] <= m_out_b;
            r_in_mem[m_wa_b]  <= m_in_b;
        end
    end

    // second port pair for edge update: out row of dst and in row of src
    logic [NV-1:0] r_rd_c, r_rd_d;
    always_ff @(posedge i_clk) begin
        if (m_rd_en) begin
            r_rd_c <= r_out_mem[m_rd_b];
            r_rd_d <= r_in_mem[m_rd_a];
        end
    end

    // stack and postorder memories
    always_ff @(posedge i_clk) begin
        if (s_push) r_stack[r_depth[VW-1:0]] <= s_push_v;
        r_stk_rd <= r_stack[n_depth[VW-1:0] - VW'(1)];
        if (s_rec) r_order[r_ocnt[VW-1:0]] <= r_top;
        r_ord_rd <= r_order[s_ord_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_vcnt <= CW'(NV);
            r_idx <= '0;
            r_ov <= 1'b0;
            r_depth <= '0;
            r_ocnt <= '0;
            r_visited <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_ov <= n_ov;
            r_depth <= n_depth;
            r_ocnt <= n_ocnt;
            r_visited <= n_visited;
            if (i_cfg_we) r_vcnt <= w_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_ovtx <= n_ovtx;
        r_olast <= n_olast;
        r_oemp <= n_oemp;
        if (i_in.valid && i_in.ready) begin
            r_src <= i_in.src;
            r_dst <= i_in.dst;
            r_n <= r_vcnt;
            r_mask <= (r_vcnt >= CW'(NV)) ? '1 : ((NV'(1) << r_vcnt[VW-1:0]) - NV'(1));
        end
    end

    // next state and datapath control
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_ov = r_ov && !o_out.ready;
        n_ovtx = r_ovtx;
        n_olast = r_olast;
        n_oemp = r_oemp;
        n_depth = r_depth;
        n_ocnt = r_ocnt;
        n_visited = r_visited;
        n_top = r_top;
        m_rd_en = 1'b0;
        m_rd_a = r_src;
        m_rd_b = r_dst;
        m_wr_en = 1'b0;
        m_wa_a = r_src;
        m_wa_b = r_dst;
        m_out_a = r_rd_a;
        m_in_a = r_rd_d;
        m_out_b = r_rd_c;
        m_in_b = r_rd_b;
        m_clr = 1'b0;
        s_push = 1'b0;
        s_rec = 1'b0;
        s_push_v = r_idx[VW-1:0];
        // postorder entry below the emit index, kept while the output stalls
        s_ord_ra = r_idx[VW-1:0] - VW'(1);
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    case (t_action'(i_in.action))
                        ACT_ADD: begin
                            if (CW'(i_in.src) < r_vcnt && CW'(i_in.dst) < r_vcnt)
                                n_state = ST_ADD_RD;
                        end
                        ACT_SORT: begin
                            n_visited = '0;
                            n_ocnt = '0;
                            n_depth = '0;
                            n_idx = '0;
                            n_state = ST_SCAN_RD;
                        end
                        ACT_CLEAR: begin
                            n_idx = '0;
                            n_state = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                m_clr = 1'b1;
                n_idx = r_idx + CW'(1);
                if (r_idx == CW'(NV - 1)) n_state = ST_IDLE;
            end
            ST_ADD_RD: begin
                m_rd_en = 1'b1;
                n_state = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                // src row first, dst row overrides on self-loop
                m_wr_en = 1'b1;
                m_out_a = r_rd_a | (NV'(1) << r_dst);
                m_in_a = r_rd_d & ~(NV'(1) << r_dst);
                m_in_b = r_rd_b | (NV'(1) << r_src);
                m_out_b = r_rd_c & ~(NV'(1) << r_src);
                if (r_src == r_dst) begin
                    m_in_b = r_rd_b | (NV'(1) << r_src);
                    m_out_b = r_rd_a & ~(NV'(1) << r_src);
                end
                n_state = ST_IDLE;
            end
            ST_SCAN_RD: begin
                if (r_idx >= r_n) begin
                    n_idx = r_ocnt;
                    n_state = (r_ocnt == '0) ? ST_EMPTY : ST_EMIT_RD;
                end else if (r_visited[r_idx[VW-1:0]]) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    m_rd_en = 1'b1;
                    m_rd_b = r_idx[VW-1:0];
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if ((r_rd_b & r_mask) != '0) begin
                    n_idx = r_idx + CW'(1);
                    n_state = ST_SCAN_RD;
                end else begin
                    s_push = 1'b1;
                    n_depth = CW'(1);
                    n_visited = r_visited | (NV'(1) << r_idx[VW-1:0]);
                    n_top = r_idx[VW-1:0];
                    n_state = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                m_rd_en = 1'b1;
                m_rd_a = r_top;
                n_state = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (w_next != '0 && r_depth < CW'(NV)) begin
                    s_push = 1'b1;
                    s_push_v = f_lowest(w_next);
                    n_top = s_push_v;
                    n_visited = r_visited | (NV'(1) << s_push_v);
                    n_depth = r_depth + CW'(1);
                    n_state = ST_WALK_RD;
                end else begin
                    s_rec = (r_ocnt < CW'(NV));
                    if (s_rec) n_ocnt = r_ocnt + CW'(1);
                    n_depth = r_depth - CW'(1);
                    if (n_depth == '0) begin
                        n_idx = r_idx + CW'(1);
                        n_state = ST_SCAN_RD;
                    end else begin
                        n_state = ST_WALK_POP;
                    end
                end
            end
            ST_EMIT_RD: begin
                s_ord_ra = r_idx[VW-1:0] - VW'(1);
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_ovtx = r_ord_rd;
                    n_oemp = 1'b0;
                    n_olast = (r_idx == CW'(1));
                    n_idx = r_idx - CW'(1);
                    n_state = (r_idx == CW'(1)) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_EMPTY: begin
                if (w_out_free) begin
                    n_ov = 1'b1;
                    n_ovtx = '0;
                    n_olast = 1'b0;
                    n_oemp = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_WALK_POP: begin
                // stack read of the new top lands this cycle
                n_top = r_stk_rd;
                n_state = ST_WALK_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // walk depth never exceeds the vertex limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_depth <= CW'(NV))
        else $error("walk depth overflow");
    // results are only produced by a sort
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == ST_EMIT_OUT || $past(r_state) == ST_EMPTY))
        else $error("result outside emit");
    // held result stays while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready |=> r_ov && $stable(r_ovtx))
        else $error("result dropped under stall");
endmodule

FILE: tb/sv/tb_dts_checker.sv
`timescale 1ns / 100ps
// checker that predicts sort order from observed transactions and compares results
module tb_dts_checker
    import dts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_data,
    dts_in_if.source      i_in,
    dts_out_if.sink       o_out,
    output int            o_errors,
    output int            o_pending
);
    typedef struct packed {
        logic [VW-1:0] vertex;
        logic          last;
        logic          empty_res;
    } t_order_item;

    logic [NV-1:0] succ_rows [NV];
    logic [NV-1:0] pred_rows [NV];
    logic [CW-1:0] vcount;
    t_order_item   order_q[$];
    int            mismatches;

    assign o_errors  = mismatches;
    assign o_pending = order_q.size();

    // graph edit: one direction per vertex pair
    task automatic load_edge(input logic [VW-1:0] s, input logic [VW-1:0] d);
        int n;
        n = (vcount > NV) ? NV : int'(vcount);
        if (int'(s) < n && int'(d) < n) begin
            succ_rows[s][d] = 1'b1;
            pred_rows[s][d] = 1'b0;
            pred_rows[d][s] = 1'b1;
            succ_rows[d][s] = 1'b0;
        end
    endtask

    // run the depth-first walk and queue the reverse postorder
    task automatic predict_order();
        int            n;
        int            depth;
        int            cnt;
        int            top;
        int            nxt;
        logic [NV-1:0] live;
        logic [NV-1:0] seen;
        logic [NV-1:0] cand;
        int            walk [NV];
        int            post [NV];
        t_order_item   it;
        n    = (vcount > NV) ? NV : int'(vcount);
        live = (n >= NV) ? '1 : ((64'd1 << n) - 64'd1);
        seen = '0;
        cnt  = 0;
        for (int v = 0; v < n; v++) begin
            if (seen[v] || (pred_rows[v] & live) != '0) continue;
            seen[v] = 1'b1;
            depth = 1;
            walk[0] = v;
            while (depth > 0) begin
                top  = walk[depth - 1];
                cand = succ_rows[top] & live & ~seen;
                if (cand != '0 && depth < NV) begin
                    nxt = 0;
                    while (!cand[nxt]) nxt++;
                    seen[nxt] = 1'b1;
                    walk[depth] = nxt;
                    depth++;
                end else begin
                    depth--;
                    if (cnt < NV) begin
                        post[cnt] = top;
                        cnt++;
                    end
                end
            end
        end
        if (cnt == 0) begin
            it = '{vertex: '0, last: 1'b0, empty_res: 1'b1};
            order_q.push_back(it);
        end
        for (int k = 0; k < cnt; k++) begin
            it = '{vertex: VW'(post[cnt - 1 - k]), last: (k == cnt - 1), empty_res: 1'b0};
            order_q.push_back(it);
        end
    endtask

    // observe both channels and the config port
    always @(posedge i_clk) begin
        t_order_item got;
        t_order_item want;
        if (!i_rst_n) begin
            for (int r = 0; r < NV; r++) begin
                succ_rows[r] = '0;
                pred_rows[r] = '0;
            end
            vcount = CW'(NV);
            mismatches <= 0;
            order_q.delete();
        end else begin
            if (i_cfg_we) vcount = i_cfg_data;
            if (i_in.valid && i_in.ready) begin
                case (t_action'(i_in.action))
                    ACT_ADD: begin
                        load_edge(i_in.src, i_in.dst);
                    end
                    ACT_SORT: begin
                        predict_order();
                    end
                    ACT_CLEAR: begin
                        for (int r = 0; r < NV; r++) begin
                            succ_rows[r] = '0;
                            pred_rows[r] = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (o_out.valid && o_out.ready) begin
                got = '{vertex: o_out.vertex, last: o_out.last, empty_res: o_out.empty_res};
                if (order_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result vertex=%0d last=%0b empty=%0b",
                                 got.vertex, got.last, got.empty_res);
                    mismatches <= mismatches + 1;
                end else begin
                    want = order_q.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("mismatch exp v=%0d l=%0b e=%0b got v=%0d l=%0b e=%0b",
                                     want.vertex, want.last, want.empty_res,
                                     got.vertex, got.last, got.empty_res);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/sv/tb_dfs_topological_sort.sv
`timescale 1ns / 100ps
// top of the sort testbench: clock, reset, stimulus and verdict
module tb_dfs_topological_sort;
    import dts_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [CW-1:0] i_cfg_data;
    int            errors;
    int            pending;
    int            idle_cycles;
    int            burst_left;
    logic          stall_mode;

    dts_in_if  in_ch ();
    dts_out_if out_ch ();

    dfs_topological_sort uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    tb_dts_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.source),
        .o_out      (out_ch.sink),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stall pattern: alternating phases of free flow and random stalls
    initial begin
        out_ch.ready = 1'b0;
        stall_mode   = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
            out_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // send one transaction, with a random gap before each new burst; valid drops at burst end
    task automatic send_item(input t_action act, input int s, input int d);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.src    <= VW'(s);
        in_ch.dst    <= VW'(d);
        do @(posedge i_clk); while (!in_ch.ready);
        if (burst_left == 0) in_ch.valid <= 1'b0;
    endtask

    // wait for every expected result, then let the block settle
    task automatic drain();
        if (burst_left != 0) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_count(input int c);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CW'(c);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random phase: mostly edges among the live vertices, then a sort
    task automatic random_phase(input int n, input int items);
        int r;
        int lim;
        lim = (n > NV) ? NV - 1 : ((n < 1) ? 0 : n - 1);
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_item(ACT_ADD, $urandom_range(0, lim), $urandom_range(0, lim));
            else if (r < 80)
                send_item(ACT_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
            else if (r < 93)
                send_item(ACT_SORT, $urandom_range(0, 63), $urandom_range(0, 63));
            else if (r < 97)
                send_item(ACT_CLEAR, 0, 0);
            else
                send_item(ACT_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
        end
        send_item(ACT_SORT, 0, 0);
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.action = ACT_ADD;
        in_ch.src    = '0;
        in_ch.dst    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        burst_left   = 0;
        i_rst_n      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty graph, chain, overwrite, self-loop, out of range, cycle
        send_item(ACT_SORT, 0, 0);
        send_item(ACT_ADD, 0, 63);
        send_item(ACT_ADD, 63, 1);
        send_item(ACT_ADD, 1, 2);
        send_item(ACT_ADD, 2, 1);
        send_item(ACT_ADD, 5, 5);
        send_item(ACT_ADD, 7, 8);
        send_item(ACT_ADD, 8, 9);
        send_item(ACT_ADD, 9, 7);
        send_item(ACT_NONE, 63, 63);
        send_item(ACT_SORT, 0, 0);
        write_count(4);
        send_item(ACT_ADD, 3, 40);
        send_item(ACT_ADD, 3, 2);
        send_item(ACT_SORT, 0, 0);
        send_item(ACT_CLEAR, 0, 0);
        send_item(ACT_SORT, 0, 0);
        write_count(0);
        send_item(ACT_ADD, 0, 0);
        send_item(ACT_SORT, 0, 0);
        write_count(127);
        send_item(ACT_ADD, 42, 21);
        send_item(ACT_SORT, 0, 0);
        write_count(1);
        send_item(ACT_SORT, 0, 0);

        // random phases over several vertex counts
        write_count(8);
        send_item(ACT_CLEAR, 0, 0);
        random_phase(8, 35);
        drain();
        write_count(64);
        random_phase(64, 30);
        write_count(3);
        random_phase(3, 20);
        write_count(20);
        send_item(ACT_CLEAR, 0, 0);
        random_phase(20, 35);
        write_count(100);
        random_phase(64, 25);

        drain();
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
